// ===== rtl/core/sha256_byte_stream_hasher_top_defines.svh =====
// assertion macros for the sha-256 byte stream hasher
// used by sha256_byte_stream_hasher_top; expects clk and rst_n in scope
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SBSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SBSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sbsh_pkg.sv =====
// shared types and constants for the sha-256 byte stream hasher
// no dependencies; imported by every module of the block
package sbsh_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] hash_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN,
        PAD_DONE
    } pad_step_t;

    // commands from the sequencer to the schedule window
    typedef struct packed {
        logic       load_byte;
        logic       load_word;
        logic [7:0] byte_val;
    } sched_ctrl_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL = 6'd56;
    localparam logic [5:0] LAST_SLOT = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t [0:63] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== rtl/core/sbsh_if.sv =====
// valid/ready channel interfaces for the sha-256 byte stream hasher
// no dependencies; one interface for message bytes, one for digest words
interface sbsh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output message_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink (input valid, input message_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

interface sbsh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

// ===== rtl/core/sbsh_sched.sv =====
// message buffer and schedule window for the sha-256 byte stream hasher
// depends on sbsh_pkg; bytes shift in one at a time, rounds shift words
module sbsh_sched (
    input  logic                clk,
    input  sbsh_pkg::sched_ctrl_t ctrl,
    output sbsh_pkg::word_t     w_cur
);
    import sbsh_pkg::*;

    logic [511:0] window_reg;
    logic [511:0] window_next;
    word_t        w1;
    word_t        w9;
    word_t        w14;
    word_t        sig0;
    word_t        sig1;
    word_t        w_new;

    // oldest word sits at the top of the window
    assign w_cur = window_reg[511:480];
    assign w1    = window_reg[479:448];
    assign w9    = window_reg[223:192];
    assign w14   = window_reg[63:32];

    // small sigma functions of the expansion
    assign sig0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
    assign sig1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]}
                ^ {10'b0, w14[31:10]};
    assign w_new = w_cur + sig0 + w9 + sig1;

    // byte load or word expansion
    always_comb
    begin
        window_next = window_reg;
        if (ctrl.load_byte)
        begin
            window_next = {window_reg[503:0], ctrl.byte_val};
        end
        else if (ctrl.load_word)
        begin
            window_next = {window_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

endmodule

// ===== rtl/core/sbsh_round.sv =====
// one sha-256 compression round, the shared unit of the hasher
// depends on sbsh_pkg; purely combinational, registered by the caller
module sbsh_round (
    input  sbsh_pkg::hash_t v,
    input  sbsh_pkg::word_t k,
    input  sbsh_pkg::word_t w,
    output sbsh_pkg::hash_t v_new
);
    import sbsh_pkg::*;

    word_t a;
    word_t e;
    word_t big0;
    word_t big1;
    word_t choose;
    word_t major;
    word_t t1;

    assign a = v[0];
    assign e = v[4];

    // round functions
    assign big1   = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    assign choose = (e & v[5]) ^ (~e & v[6]);
    assign big0   = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    assign major  = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);
    assign t1     = v[7] + big1 + choose + k + w;

    // rotate the working words
    always_comb
    begin
        v_new[7] = v[6];
        v_new[6] = v[5];
        v_new[5] = v[4];
        v_new[4] = v[3] + t1;
        v_new[3] = v[2];
        v_new[2] = v[1];
        v_new[1] = v[0];
        v_new[0] = t1 + big0 + major;
    end

endmodule

// ===== rtl/core/sha256_byte_stream_hasher_top.sv =====
// top level of the sha-256 byte stream hasher: sequencer, chaining state
// depends on sbsh_pkg, sbsh_if, sbsh_sched, sbsh_round and the defines header
//
// usage:
//   byte_in carries one message byte per transfer (has_byte) and marks the
//   final item with end_of_message; an empty message is one final item
//   with has_byte low. digest_out returns eight 32-bit words per message,
//   word_index 0 (most significant) first, last_word high on the eighth.
// operation:
//   a byte that does not complete a 64-byte block goes straight into the
//   buffer; the byte that completes one starts the rounds and then the
//   chaining add, all on the one shared round unit. the final item pushes
//   the pad byte, the zero bytes and the big-endian bit length, running
//   one or two compressions, then the digest words go out one per cycle
//   while digest_out is ready.
// reset and stalls:
//   rst_n loads the initial hash values and clears the byte and bit counts.
//   byte_in is ready only while idle; a digest word holds until taken and
//   no byte is accepted until all eight words have been transferred.
`include "sha256_byte_stream_hasher_top_defines.svh"

module sha256_byte_stream_hasher_top (
    input  logic       clk,
    input  logic       rst_n,
    sbsh_in_if.sink    byte_in,
    sbsh_out_if.source digest_out
);
    import sbsh_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    pad_step_t   pad_reg;
    pad_step_t   pad_next;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [63:0] bitlen_reg;
    logic [63:0] bitlen_next;
    hash_t       chain_reg;
    hash_t       chain_next;
    hash_t       v_reg;
    hash_t       v_next;
    logic [5:0]  round_reg;
    logic [5:0]  round_next;
    logic [2:0]  len_cnt_reg;
    logic [2:0]  len_cnt_next;
    logic        eom_reg;
    logic        eom_next;
    logic [2:0]  out_idx_reg;
    logic [2:0]  out_idx_next;

    logic        push;
    logic [7:0]  push_val;
    sched_ctrl_t sched_ctrl;
    word_t       w_cur;
    hash_t       v_round;

    // message buffer and schedule
    sbsh_sched u_sched (
        .clk   (clk),
        .ctrl  (sched_ctrl),
        .w_cur (w_cur)
    );

    // shared round unit
    sbsh_round u_round (
        .v     (v_reg),
        .k     (ROUND_K[round_reg]),
        .w     (w_cur),
        .v_new (v_round)
    );

    // digest output
    assign digest_out.valid       = (state_reg == ST_OUT);
    assign digest_out.digest_word = chain_reg[out_idx_reg];
    assign digest_out.word_index  = out_idx_reg;
    assign digest_out.last_word   = (out_idx_reg == LAST_WORD_IDX);
    assign byte_in.ready          = (state_reg == ST_IDLE);

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        pad_next     = pad_reg;
        fill_next    = fill_reg;
        bitlen_next  = bitlen_reg;
        chain_next   = chain_reg;
        v_next       = v_reg;
        round_next   = round_reg;
        len_cnt_next = len_cnt_reg;
        eom_next     = eom_reg;
        out_idx_next = out_idx_reg;
        push         = 1'b0;
        push_val     = byte_in.message_byte;
        sched_ctrl   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_in.valid)
                begin
                    if (byte_in.has_byte)
                    begin
                        push        = 1'b1;
                        bitlen_next = bitlen_reg + 64'd8;
                    end
                    eom_next = byte_in.end_of_message;
                    if (byte_in.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                sched_ctrl.load_word = 1'b1;
                v_next     = v_round;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                if (pad_reg == PAD_DONE)
                begin
                    state_next = ST_OUT;
                end
                else if (eom_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                unique case (pad_reg)
                    PAD_MARK:
                    begin
                        push     = 1'b1;
                        push_val = PAD_BYTE;
                        pad_next = PAD_ZERO;
                    end
                    PAD_ZERO:
                    begin
                        if (fill_reg == LEN_FILL)
                        begin
                            pad_next = PAD_LEN;
                        end
                        else
                        begin
                            push     = 1'b1;
                            push_val = 8'h00;
                        end
                    end
                    PAD_LEN:
                    begin
                        // length goes out big-endian; shifting leaves zero behind
                        push         = 1'b1;
                        push_val     = bitlen_reg[63:56];
                        bitlen_next  = {bitlen_reg[55:0], 8'h00};
                        len_cnt_next = len_cnt_reg + 3'd1;
                        if (len_cnt_reg == LAST_WORD_IDX)
                        begin
                            pad_next = PAD_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT:
            begin
                if (digest_out.ready)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD_IDX)
                    begin
                        chain_next = INIT_HASH;
                        eom_next   = 1'b0;
                        pad_next   = PAD_MARK;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // byte into the buffer; a full block starts the compression
        if (push)
        begin
            sched_ctrl.load_byte = 1'b1;
            sched_ctrl.byte_val  = push_val;
            fill_next            = fill_reg + 6'd1;
            if (fill_reg == LAST_SLOT)
            begin
                state_next = ST_ROUND;
                v_next     = chain_reg;
                round_next = '0;
            end
        end
    end

    // control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pad_reg     <= PAD_MARK;
            fill_reg    <= '0;
            bitlen_reg  <= '0;
            chain_reg   <= INIT_HASH;
            round_reg   <= '0;
            len_cnt_reg <= '0;
            eom_reg     <= 1'b0;
            out_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pad_reg     <= pad_next;
            fill_reg    <= fill_next;
            bitlen_reg  <= bitlen_next;
            chain_reg   <= chain_next;
            round_reg   <= round_next;
            len_cnt_reg <= len_cnt_next;
            eom_reg     <= eom_next;
            out_idx_reg <= out_idx_next;
        end
    end

    // working words
    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    // checks
    `SBSH_ASSERT_NOW(a_no_overlap, byte_in.ready, !digest_out.valid,
        "input accepted while digest pending")
    `SBSH_ASSERT_NEXT(a_round_end, (state_reg == ST_ROUND) && (round_reg == LAST_ROUND),
        state_reg == ST_ADD, "compression did not end after last round")
    `SBSH_ASSERT_NEXT(a_restart,
        digest_out.valid && digest_out.ready && digest_out.last_word,
        (state_reg == ST_IDLE) && (fill_reg == 6'd0) && (bitlen_reg == 64'd0),
        "hasher not cleared after digest")
    `SBSH_ASSERT_NOW(a_first_word, $rose(digest_out.valid), digest_out.word_index == 3'd0,
        "digest does not start at word zero")

endmodule
